// File: sv/rgb_to_hsv_pixel_defines.svh
// Assertion macros for the RGB to HSV pixel block.
// Included by the checker; needs clk and rst_n in the including scope.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define RHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RHP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rhp_pkg.sv
// Shared constants and types for the RGB to HSV pixel pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rhp_pkg;

  localparam int COMPONENT_BITS_DEF = 8;
  localparam int FRACTION_BITS_DEF  = 16;

  // Special-case flags carried alongside each pixel to the output select.
  typedef struct packed {
    logic grey;   // chroma zero: hue forced to zero
    logic black;  // value zero: saturation forced to zero
    logic full;   // minimum zero: chroma equals value, saturation clamps
  } rhp_flags_t;

endpackage

// File: sv/rhp_front.sv
// Front end: two stages finding max/min, chroma, hue numerator and 6C.
// Depends on rhp_pkg.
`timescale 1ns / 1ps

module rhp_front #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      o_valid,
  input  logic                      o_ready,
  output logic [COMPONENT_BITS-1:0] o_value,
  output logic [COMPONENT_BITS-1:0] o_chroma,
  output logic [COMPONENT_BITS+2:0] o_num,
  output logic [COMPONENT_BITS+2:0] o_div6,
  output rhp_pkg::rhp_flags_t       o_flags
);
  import rhp_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int NW = COMPONENT_BITS + 3;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // stage A
  logic          vld_a_r, vld_a_nxt;
  logic [CB-1:0] r_a_r, g_a_r, b_a_r, v_a_r, m_a_r;
  logic [CB-1:0] r_a_nxt, g_a_nxt, b_a_nxt, v_a_nxt, m_a_nxt;
  logic [1:0]    sel_a_r, sel_a_nxt;
  logic [CB-1:0] mx_rg, mn_rg, mx, mn;
  logic [1:0]    sel;

  // stage B
  logic          vld_b_r, vld_b_nxt;
  logic [CB-1:0] v_b_r, c_b_r, v_b_nxt, c_b_nxt;
  logic [NW-1:0] num_b_r, d6_b_r, num_b_nxt, d6_b_nxt;
  rhp_flags_t    flg_b_r, flg_b_nxt;
  logic [CB-1:0] c_a;
  logic [NW-1:0] c_w, d6, num;

  logic mv_a, mv_b;

  assign mv_b     = !vld_b_r || o_ready;
  assign mv_a     = !vld_a_r || mv_b;
  assign in_ready = mv_a;

  // on a tie for the maximum, blue has priority over green and green over red
  always_comb begin
    mx_rg = (in_red > in_green) ? in_red : in_green;
    mn_rg = (in_red < in_green) ? in_red : in_green;
    mx    = (mx_rg > in_blue) ? mx_rg : in_blue;
    mn    = (mn_rg < in_blue) ? mn_rg : in_blue;
    priority if (mx == in_blue) begin
      sel = SEL_BLUE;
    end else if (mx == in_green) begin
      sel = SEL_GREEN;
    end else begin
      sel = SEL_RED;
    end
  end

  always_comb begin
    vld_a_nxt = mv_a ? in_valid : vld_a_r;
    r_a_nxt   = mv_a ? in_red   : r_a_r;
    g_a_nxt   = mv_a ? in_green : g_a_r;
    b_a_nxt   = mv_a ? in_blue  : b_a_r;
    v_a_nxt   = mv_a ? mx       : v_a_r;
    m_a_nxt   = mv_a ? mn       : m_a_r;
    sel_a_nxt = mv_a ? sel      : sel_a_r;
  end

  always_comb begin
    c_a = v_a_r - m_a_r;
    c_w = NW'(c_a);
    d6  = (c_w << 2) + (c_w << 1);
    unique case (sel_a_r)
      SEL_BLUE:  num = NW'(r_a_r) + (c_w << 2) - NW'(g_a_r);
      SEL_GREEN: num = NW'(b_a_r) + (c_w << 1) - NW'(r_a_r);
      SEL_RED: begin
        // negative numerator wraps by a full turn
        if (g_a_r >= b_a_r) begin
          num = NW'(g_a_r) - NW'(b_a_r);
        end else begin
          num = d6 - (NW'(b_a_r) - NW'(g_a_r));
        end
      end
      default:   num = '0;
    endcase
  end

  always_comb begin
    vld_b_nxt = mv_b ? vld_a_r : vld_b_r;
    v_b_nxt   = mv_b ? v_a_r   : v_b_r;
    c_b_nxt   = mv_b ? c_a     : c_b_r;
    num_b_nxt = mv_b ? num     : num_b_r;
    d6_b_nxt  = mv_b ? d6      : d6_b_r;
    if (mv_b) begin
      flg_b_nxt.grey  = (c_a == '0);
      flg_b_nxt.black = (v_a_r == '0);
      flg_b_nxt.full  = (m_a_r == '0);
    end else begin
      flg_b_nxt = flg_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_a_nxt;
      vld_b_r <= vld_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_a_r   <= r_a_nxt;
    g_a_r   <= g_a_nxt;
    b_a_r   <= b_a_nxt;
    v_a_r   <= v_a_nxt;
    m_a_r   <= m_a_nxt;
    sel_a_r <= sel_a_nxt;
    v_b_r   <= v_b_nxt;
    c_b_r   <= c_b_nxt;
    num_b_r <= num_b_nxt;
    d6_b_r  <= d6_b_nxt;
    flg_b_r <= flg_b_nxt;
  end

  assign o_valid  = vld_b_r;
  assign o_value  = v_b_r;
  assign o_chroma = c_b_r;
  assign o_num    = num_b_r;
  assign o_div6   = d6_b_r;
  assign o_flags  = flg_b_r;

endmodule

// File: sv/rhp_div.sv
// Twin restoring dividers, one quotient bit per stage, FRACTION_BITS stages.
// Lane S: (C << F) / V.  Lane H: (num << F) / 6C.  Depends on rhp_pkg.
`timescale 1ns / 1ps

module rhp_div #(
  parameter int COMPONENT_BITS = 8,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      i_valid,
  output logic                      i_ready,
  input  logic [COMPONENT_BITS-1:0] i_value,
  input  logic [COMPONENT_BITS-1:0] i_chroma,
  input  logic [COMPONENT_BITS+2:0] i_num,
  input  logic [COMPONENT_BITS+2:0] i_div6,
  input  rhp_pkg::rhp_flags_t       i_flags,
  output logic                      o_valid,
  input  logic                      o_ready,
  output logic [COMPONENT_BITS-1:0] o_value,
  output logic [FRACTION_BITS-1:0]  o_sat_q,
  output logic [FRACTION_BITS-1:0]  o_hue_q,
  output rhp_pkg::rhp_flags_t       o_flags
);
  import rhp_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int NW = COMPONENT_BITS + 3;
  localparam int FB = FRACTION_BITS;

  logic [FB-1:0] vld_r;
  logic [FB-1:0] mv;
  logic [CB-1:0] v_r    [FB];
  logic [CB-1:0] srem_r [FB];
  logic [NW-1:0] hrem_r [FB];
  logic [NW-1:0] hd_r   [FB];
  logic [FB-1:0] sq_r   [FB];
  logic [FB-1:0] hq_r   [FB];
  rhp_flags_t    flg_r  [FB];

  for (genvar k = 0; k < FB; k++) begin : g_step
    logic          vld_p, vld_nxt;
    logic [CB-1:0] v_p, srem_p, srem_nxt, v_nxt;
    logic [NW-1:0] hrem_p, hd_p, hrem_nxt, hd_nxt;
    logic [FB-1:0] sq_p, hq_p, sq_nxt, hq_nxt;
    rhp_flags_t    flg_p, flg_nxt;
    logic [CB:0]   st;
    logic [NW:0]   ht;
    logic          sge, hge;

    if (k == 0) begin : g_first
      assign vld_p  = i_valid;
      assign v_p    = i_value;
      assign srem_p = i_chroma;
      assign hrem_p = i_num;
      assign hd_p   = i_div6;
      assign sq_p   = '0;
      assign hq_p   = '0;
      assign flg_p  = i_flags;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign v_p    = v_r[k-1];
      assign srem_p = srem_r[k-1];
      assign hrem_p = hrem_r[k-1];
      assign hd_p   = hd_r[k-1];
      assign sq_p   = sq_r[k-1];
      assign hq_p   = hq_r[k-1];
      assign flg_p  = flg_r[k-1];
    end

    if (k == FB - 1) begin : g_last_mv
      assign mv[k] = !vld_r[k] || o_ready;
    end else begin : g_mid_mv
      assign mv[k] = !vld_r[k] || mv[k+1];
    end

    // remainder stays below the divisor on every case whose quotient is used
    always_comb begin
      st  = {srem_p, 1'b0};
      ht  = {hrem_p, 1'b0};
      sge = (st >= {1'b0, v_p});
      hge = (ht >= {1'b0, hd_p});
      vld_nxt  = mv[k] ? vld_p : vld_r[k];
      v_nxt    = mv[k] ? v_p   : v_r[k];
      hd_nxt   = mv[k] ? hd_p  : hd_r[k];
      flg_nxt  = mv[k] ? flg_p : flg_r[k];
      srem_nxt = srem_r[k];
      hrem_nxt = hrem_r[k];
      sq_nxt   = sq_r[k];
      hq_nxt   = hq_r[k];
      if (mv[k]) begin
        srem_nxt = sge ? CB'(st - {1'b0, v_p}) : CB'(st);
        hrem_nxt = hge ? NW'(ht - {1'b0, hd_p}) : NW'(ht);
        sq_nxt   = {sq_p[FB-2:0], sge};
        hq_nxt   = {hq_p[FB-2:0], hge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      v_r[k]    <= v_nxt;
      srem_r[k] <= srem_nxt;
      hrem_r[k] <= hrem_nxt;
      hd_r[k]   <= hd_nxt;
      sq_r[k]   <= sq_nxt;
      hq_r[k]   <= hq_nxt;
      flg_r[k]  <= flg_nxt;
    end
  end

  assign i_ready = mv[0];
  assign o_valid = vld_r[FB-1];
  assign o_value = v_r[FB-1];
  assign o_sat_q = sq_r[FB-1];
  assign o_hue_q = hq_r[FB-1];
  assign o_flags = flg_r[FB-1];

endmodule

// File: sv/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter: front end, divider pipe,
// output register with special-case select. Depends on rhp_pkg, rhp_front, rhp_div.
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | in        | in_valid / in_ready | in_red, in_green, in_blue
//  out_    | out       | out_valid/out_ready | out_hue, out_saturation, out_brightness
//
//  One pixel per clock sustained while out_ready stays high; the path runs through two
//  front stages, one divider stage per quotient bit and one output stage.
//  Every stage has its own valid bit; a stage loads when empty or when the one
//  after it moves, so bubbles close up and a stall on out_ready holds all data.
//  Synchronous active-low reset clears the valid bits only.

module rgb_to_hsv_pixel #(
  parameter int COMPONENT_BITS = rhp_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = rhp_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [FRACTION_BITS-1:0]  out_hue,
  output logic [FRACTION_BITS-1:0]  out_saturation,
  output logic [COMPONENT_BITS-1:0] out_brightness
);
  import rhp_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int NW = COMPONENT_BITS + 3;
  localparam int FB = FRACTION_BITS;

  logic          f_valid, f_ready;
  logic [CB-1:0] f_value, f_chroma;
  logic [NW-1:0] f_num, f_div6;
  rhp_flags_t    f_flags;

  logic          d_valid, d_ready;
  logic [CB-1:0] d_value;
  logic [FB-1:0] d_sat_q, d_hue_q;
  rhp_flags_t    d_flags;

  logic          out_valid_r, out_valid_nxt;
  logic [FB-1:0] hue_r, hue_nxt, sat_r, sat_nxt;
  logic [CB-1:0] bri_r, bri_nxt;

  rhp_front #(
    .COMPONENT_BITS(CB)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .o_valid  (f_valid),
    .o_ready  (f_ready),
    .o_value  (f_value),
    .o_chroma (f_chroma),
    .o_num    (f_num),
    .o_div6   (f_div6),
    .o_flags  (f_flags)
  );

  rhp_div #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS (FB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (f_valid),
    .i_ready  (f_ready),
    .i_value  (f_value),
    .i_chroma (f_chroma),
    .i_num    (f_num),
    .i_div6   (f_div6),
    .i_flags  (f_flags),
    .o_valid  (d_valid),
    .o_ready  (d_ready),
    .o_value  (d_value),
    .o_sat_q  (d_sat_q),
    .o_hue_q  (d_hue_q),
    .o_flags  (d_flags)
  );

  assign d_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = d_ready ? d_valid : out_valid_r;
    hue_nxt       = hue_r;
    sat_nxt       = sat_r;
    bri_nxt       = bri_r;
    if (d_ready) begin
      bri_nxt = d_value;
      hue_nxt = d_flags.grey ? '0 : d_hue_q;
      // chroma equal to value would be exactly 1.0: clamp to all ones
      priority if (d_flags.black) begin
        sat_nxt = '0;
      end else if (d_flags.full) begin
        sat_nxt = '1;
      end else begin
        sat_nxt = d_sat_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hue_r <= hue_nxt;
    sat_r <= sat_nxt;
    bri_r <= bri_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bri_r;

endmodule

// File: sv/rhp_check.sv
// Port-level checker for rgb_to_hsv_pixel, bound to the top level below.
// Depends on rhp_pkg and rgb_to_hsv_pixel_defines.svh.
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_defines.svh"

module rhp_check #(
  parameter int COMPONENT_BITS = rhp_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = rhp_pkg::FRACTION_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [COMPONENT_BITS-1:0] in_red,
  input logic [COMPONENT_BITS-1:0] in_green,
  input logic [COMPONENT_BITS-1:0] in_blue,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [FRACTION_BITS-1:0]  out_hue,
  input logic [FRACTION_BITS-1:0]  out_saturation,
  input logic [COMPONENT_BITS-1:0] out_brightness
);
  import rhp_pkg::*;

  // an empty output register means every stage can move
  `RHP_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "in_ready low with output empty")

  // reset empties the pipe
  `RHP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid && in_ready, "pipe not empty after reset")

  // stalled transaction holds
  `RHP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_hue) && $stable(out_saturation) && $stable(out_brightness), "stalled output changed")

  // black pixel has neither saturation nor hue
  `RHP_ASSERT_NOW(a_black, out_valid && out_brightness == '0, out_saturation == '0 && out_hue == '0, "black pixel with colour")

endmodule

bind rgb_to_hsv_pixel rhp_check #(
  .COMPONENT_BITS(COMPONENT_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_rhp_check (.*);

// File: dv/rgb_to_hsv_pixel_tb.sv
// Self-checking testbench for rgb_to_hsv_pixel: directed corners, then random pixels
// with idle bursts on both channels, checked against an in-bench HSV predictor.
// Depends on rhp_pkg and rgb_to_hsv_pixel.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb;

  localparam int CB      = rhp_pkg::COMPONENT_BITS_DEF;
  localparam int FB      = rhp_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = FB + 3;
  localparam logic [FB-1:0] SAT_MAX = {FB{1'b1}};

  // Random pixel flavours
  typedef enum int {
    PIX_ANY,
    PIX_GREY,
    PIX_TIE_MAX,
    PIX_TIE_MIN,
    PIX_EXTREME,
    PIX_DIM
  } pix_kind_t;

  typedef struct {
    logic [FB-1:0] hue;
    logic [FB-1:0] sat;
    logic [CB-1:0] val;
  } hsv_t;

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_ready;
  logic [CB-1:0] in_red         = '0;
  logic [CB-1:0] in_green       = '0;
  logic [CB-1:0] in_blue        = '0;
  logic          out_valid;
  logic          out_ready      = 1'b0;
  logic [FB-1:0] out_hue;
  logic [FB-1:0] out_saturation;
  logic [CB-1:0] out_brightness;

  hsv_t pending_hsv[$];
  int   err_count = 0;
  bit   idle_en   = 1'b0;

  always #4 clk = ~clk;

  rgb_to_hsv_pixel u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness)
  );

  function automatic hsv_t predict_hsv(input logic [CB-1:0] r, g, b);
    logic [31:0] rr, gg, bb, vmax, vmin, chroma, num, quo;
    hsv_t        res;
    rr = 32'(r);
    gg = 32'(g);
    bb = 32'(b);
    vmax = rr;
    if (gg > vmax) vmax = gg;
    if (bb > vmax) vmax = bb;
    vmin = rr;
    if (gg < vmin) vmin = gg;
    if (bb < vmin) vmin = bb;
    chroma = vmax - vmin;
    res.val = vmax[CB-1:0];
    res.sat = '0;
    res.hue = '0;
    // black: saturation stays zero
    if (vmax != 0) begin
      quo = (chroma << FB) / vmax;
      res.sat = (quo > 32'(SAT_MAX)) ? SAT_MAX : quo[FB-1:0];
    end
    // grey: hue stays zero; blue wins ties over green, green over red
    if (chroma != 0) begin
      if (vmax == bb)
        num = rr + 4 * chroma - gg;
      else if (vmax == gg)
        num = bb + 2 * chroma - rr;
      else if (gg >= bb)
        num = gg - bb;
      else
        num = 6 * chroma - (bb - gg);
      quo = (num << FB) / (6 * chroma);
      res.hue = quo[FB-1:0];
    end
    return res;
  endfunction

  function automatic logic [3*CB-1:0] rand_pixel(input pix_kind_t kind);
    logic [CB-1:0] a, b, c;
    logic [CB-1:0] p [3];
    int            k;
    a = CB'($urandom);
    b = CB'($urandom);
    c = CB'($urandom);
    k = $urandom_range(0, 2);
    case (kind)
      PIX_GREY: begin
        b = a;
        c = a;
      end
      PIX_TIE_MAX: begin
        if (b > a) a = b;
        b = a;
        if (c > a) c = a;
      end
      PIX_TIE_MIN: begin
        if (b < a) a = b;
        b = a;
        if (c < a) c = a;
      end
      PIX_EXTREME: begin
        a = $urandom_range(0, 1) ? '1 : '0;
        b = $urandom_range(0, 1) ? '1 : '0;
      end
      PIX_DIM: begin
        a = CB'($urandom_range(0, 3));
        b = CB'($urandom_range(0, 3));
        c = CB'($urandom_range(0, 3));
      end
      default: ;
    endcase
    // rotate so any channel can take any role
    p[k]           = a;
    p[(k + 1) % 3] = b;
    p[(k + 2) % 3] = c;
    if ($urandom_range(0, 1)) return {p[0], p[1], p[2]};
    return {p[2], p[1], p[0]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // One input transaction; expectation is queued on acceptance
  task automatic send_pixel(input logic [CB-1:0] r, g, b);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    pending_hsv.push_back(predict_hsv(r, g, b));
  endtask

  task automatic send_random(input pix_kind_t kind);
    logic [3*CB-1:0] pix;
    pix = rand_pixel(kind);
    send_pixel(pix[3*CB-1:2*CB], pix[2*CB-1:CB], pix[CB-1:0]);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white
    send_pixel(8'd128, 8'd128, 8'd128);  // grey
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie
    send_pixel(8'd0,   8'd255, 8'd255);  // green/blue tie
    send_pixel(8'd255, 8'd0,   8'd255);  // red/blue tie
    send_pixel(8'd255, 8'd0,   8'd10);   // red sector, wraps below zero
    send_pixel(8'd255, 8'd10,  8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'hAA,  8'h55,  8'hAA);
    send_pixel(8'h55,  8'hAA,  8'h55);
    send_pixel(8'd255, 8'd0,   8'd254);
    send_pixel(8'd0,   8'd254, 8'd255);
    send_pixel(8'd1,   8'd0,   8'd255);
    send_pixel(8'd200, 8'd100, 8'd150);  // nothing saturates
  endtask

  task automatic test_random_mix(input int n);
    pix_kind_t kind;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 1) == 0) ? PIX_ANY : pix_kind_t'($urandom_range(1, 5));
      send_random(kind);
    end
  endtask

  // Sender holds off mid-stream until the pipeline has emptied
  task automatic test_drain_pause(input int n);
    for (int i = 0; i < n; i++) begin
      send_random(PIX_ANY);
      if (i == n / 2) wait_all_results();
    end
    wait_all_results();
  endtask

  task automatic test_ties(input int n);
    for (int i = 0; i < n; i++)
      send_random(($urandom_range(0, 1) == 0) ? PIX_TIE_MAX : PIX_TIE_MIN);
  endtask

  task automatic test_streaming(input int n);
    for (int i = 0; i < n; i++) send_random(PIX_ANY);
  endtask

  initial begin : sink_ready
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idle_en && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    hsv_t exp_hsv;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hsv.size() == 0) begin
        report_mismatch($sformatf("result transaction with nothing expected: h=%h s=%h v=%h",
                                  out_hue, out_saturation, out_brightness));
      end else begin
        exp_hsv = pending_hsv.pop_front();
        if (out_hue !== exp_hsv.hue)
          report_mismatch($sformatf("hue: got %h, want %h", out_hue, exp_hsv.hue));
        if (out_saturation !== exp_hsv.sat)
          report_mismatch($sformatf("saturation: got %h, want %h",
                                    out_saturation, exp_hsv.sat));
        if (out_brightness !== exp_hsv.val)
          report_mismatch($sformatf("brightness: got %h, want %h",
                                    out_brightness, exp_hsv.val));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_en = 1'b1;
    test_directed();
    test_random_mix(220);
    test_drain_pause(60);
    test_ties(80);
    // last stretch runs flat out
    idle_en = 1'b0;
    test_streaming(150);
    wait_all_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (pending_hsv.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_hsv.size()));
    if (err_count == 0)
      $display("rgb_to_hsv_pixel_tb: done, clean");
    else
      $display("rgb_to_hsv_pixel_tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("ERROR: timeout, %0d results outstanding", pending_hsv.size());
    $display("rgb_to_hsv_pixel_tb: done, errors");
    $finish;
  end

endmodule
